>>> src/crfb_pkg.sv
// Package with the command codes and sequencer states of the clipped fill and blit framebuffer.
package crfb_pkg;

    typedef enum logic [2:0] {
        CMD_FILL       = 3'd0,
        CMD_BLIT_START = 3'd1,
        CMD_BLIT_PIXEL = 3'd2,
        CMD_READ       = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL_MIR,
        ST_FILL_CLIP,
        ST_BLIT,
        ST_READ_CHK,
        ST_ADDR,
        ST_FILL,
        ST_WRITE,
        ST_READ,
        ST_RESULT
    } t_state;

    localparam int unsigned PIX_W = 16;
    localparam int unsigned CRD_W = 16;

endpackage

>>> src/clipped_rect_fill_blit_framebuffer_top.sv
// Top level of the clipped rectangle fill and bitmap blit framebuffer.
//
//  Channel  Direction  Ports                   Contents
//  s_axis   in         i_s_axis_t*/o_s_axis_*  one command: tuser = cmd, tdata = coords, color
//  m_axis   out        o_m_axis_t*/i_m_axis_*  pixel value returned by a read command
//
// Commands are accepted only in the idle state, one at a time. The single write port
// of the frame store is driven by one address register and one row multiplier.
// Reset (synchronous, active low) starts a zeroing pass over the whole store; no
// command is taken during it. A read result waits in its own register, so new
// commands keep flowing while the result side stalls; only a second read has to wait
// for it to drain.
module clipped_rect_fill_blit_framebuffer_top #(
    parameter int unsigned FRAME_WIDTH  = 320,
    parameter int unsigned FRAME_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0 up: pos_x[15:0], pos_y[31:16], span_w[47:32],
    // span_h[63:48], color[79:64].
    input  logic [79:0] i_s_axis_tdata,
    // Fields from bit 0 up: cmd[2:0].
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0 up: pixel_value[15:0].
    output logic [15:0] o_m_axis_tdata
);
    import crfb_pkg::*;

    localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW    = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int unsigned YW    = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam logic signed [17:0] FW_S = 18'(FRAME_WIDTH);
    localparam logic signed [17:0] FH_S = 18'(FRAME_HEIGHT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // The frame store, one write port and one registered read port.
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic             w_we;
    logic [PIX_W-1:0] w_wdata;

    t_state r_state, n_state;
    t_cmd   r_op, n_op;

    // Latched command payload.
    logic [CRD_W-1:0] r_px, r_py, r_sw, r_sh;
    logic [PIX_W-1:0] r_color;
    logic [CRD_W-1:0] n_px, n_py, n_sw, n_sh;
    logic [PIX_W-1:0] n_color;

    // Shared address register and working coordinates.
    logic [AW-1:0]    r_addr, n_addr;
    logic [XW-1:0]    r_tx, n_tx, r_x0, n_x0, r_xl, n_xl;
    logic [YW-1:0]    r_ty, n_ty, r_yl, n_yl;
    logic [XW:0]      r_skip, n_skip;
    logic             r_hit, n_hit;
    logic signed [17:0] r_fx, n_fx, r_fy, n_fy, r_fw, n_fw, r_fh, n_fh;

    // Bitmap progress.
    logic signed [CRD_W-1:0] r_blit_ox, r_blit_oy, r_blit_w, r_blit_h;
    logic signed [CRD_W-1:0] n_blit_ox, n_blit_oy, n_blit_w, n_blit_h;
    logic [CRD_W-1:0] r_blit_row, r_blit_col, n_blit_row, n_blit_col;
    logic [CRD_W-1:0] blit_col_inc;

    // Result register.
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_data, n_out_data;

    // Combinational temporaries.
    logic signed [17:0] sx, sy, sw, sh;
    logic signed [17:0] fxe, fye, fx0, fy0, fx1, fy1, fx1m, fy1m, fspan;
    logic signed [17:0] bx, by;
    logic               fill_row_end;
    logic [AW-1:0]      addr_inc;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_blit_ox   <= '0;
            r_blit_oy   <= '0;
            r_blit_w    <= '0;
            r_blit_h    <= '0;
            r_blit_row  <= '0;
            r_blit_col  <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            r_blit_ox   <= n_blit_ox;
            r_blit_oy   <= n_blit_oy;
            r_blit_w    <= n_blit_w;
            r_blit_h    <= n_blit_h;
            r_blit_row  <= n_blit_row;
            r_blit_col  <= n_blit_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_px       <= n_px;
        r_py       <= n_py;
        r_sw       <= n_sw;
        r_sh       <= n_sh;
        r_color    <= n_color;
        r_tx       <= n_tx;
        r_ty       <= n_ty;
        r_x0       <= n_x0;
        r_xl       <= n_xl;
        r_yl       <= n_yl;
        r_skip     <= n_skip;
        r_hit      <= n_hit;
        r_fx       <= n_fx;
        r_fy       <= n_fy;
        r_fw       <= n_fw;
        r_fh       <= n_fh;
        r_out_data <= n_out_data;
    end

    // Datapath terms that the sequencer picks from.
    always_comb begin
        sx = {{2{r_px[15]}}, r_px};
        sy = {{2{r_py[15]}}, r_py};
        sw = {{2{r_sw[15]}}, r_sw};
        sh = {{2{r_sh[15]}}, r_sh};

        fxe  = r_fx + r_fw;
        fye  = r_fy + r_fh;
        fx0  = r_fx[17] ? 18'sd0 : r_fx;
        fy0  = r_fy[17] ? 18'sd0 : r_fy;
        fx1  = (fxe > FW_S) ? FW_S : fxe;
        fy1  = (fye > FH_S) ? FH_S : fye;
        fx1m = fx1 - 18'sd1;
        fy1m = fy1 - 18'sd1;
        fspan = FW_S - (fx1 - fx0) + 18'sd1;

        bx = {{2{r_blit_ox[15]}}, r_blit_ox} + {2'b00, r_blit_col};
        by = {{2{r_blit_oy[15]}}, r_blit_oy} + {2'b00, r_blit_row};
        blit_col_inc = r_blit_col + 16'd1;

        // At the end of a fill row the address jumps to the left edge of the next one.
        fill_row_end = (r_tx == r_xl);
        addr_inc     = fill_row_end ? AW'(r_skip) : AW'(1);
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_px        = r_px;
        n_py        = r_py;
        n_sw        = r_sw;
        n_sh        = r_sh;
        n_color     = r_color;
        n_addr      = r_addr;
        n_tx        = r_tx;
        n_ty        = r_ty;
        n_x0        = r_x0;
        n_xl        = r_xl;
        n_yl        = r_yl;
        n_skip      = r_skip;
        n_hit       = r_hit;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_fw        = r_fw;
        n_fh        = r_fh;
        n_blit_ox   = r_blit_ox;
        n_blit_oy   = r_blit_oy;
        n_blit_w    = r_blit_w;
        n_blit_h    = r_blit_h;
        n_blit_row  = r_blit_row;
        n_blit_col  = r_blit_col;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_wdata     = r_color;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                // Zeroing sweep, used after reset and for the clear command.
                w_we    = 1'b1;
                w_wdata = '0;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op    = t_cmd'(i_s_axis_tuser);
                    n_px    = i_s_axis_tdata[15:0];
                    n_py    = i_s_axis_tdata[31:16];
                    n_sw    = i_s_axis_tdata[47:32];
                    n_sh    = i_s_axis_tdata[63:48];
                    n_color = i_s_axis_tdata[79:64];
                    case (i_s_axis_tuser)
                        CMD_FILL:       n_state = ST_FILL_MIR;
                        CMD_BLIT_START: begin
                            n_blit_ox  = i_s_axis_tdata[15:0];
                            n_blit_oy  = i_s_axis_tdata[31:16];
                            n_blit_w   = i_s_axis_tdata[47:32];
                            n_blit_h   = i_s_axis_tdata[63:48];
                            n_blit_row = '0;
                            n_blit_col = '0;
                        end
                        CMD_BLIT_PIXEL: n_state = ST_BLIT;
                        CMD_READ:       n_state = ST_READ_CHK;
                        CMD_CLEAR: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL_MIR: begin
                // A negative span flips the rectangle to the other side of its corner.
                if (r_sw == '0 || r_sh == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_fx    = sw[17] ? (sx + sw + 18'sd1) : sx;
                    n_fw    = sw[17] ? -sw : sw;
                    n_fy    = sh[17] ? (sy + sh + 18'sd1) : sy;
                    n_fh    = sh[17] ? -sh : sh;
                    n_state = ST_FILL_CLIP;
                end
            end
            ST_FILL_CLIP: begin
                if (fx0 >= fx1 || fy0 >= fy1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_tx    = fx0[XW-1:0];
                    n_x0    = fx0[XW-1:0];
                    n_xl    = fx1m[XW-1:0];
                    n_ty    = fy0[YW-1:0];
                    n_yl    = fy1m[YW-1:0];
                    n_skip  = fspan[XW:0];
                    n_state = ST_ADDR;
                end
            end
            ST_BLIT: begin
                if (r_blit_w <= 16'sd0 || r_blit_h <= 16'sd0 ||
                    $signed(r_blit_row) >= r_blit_h) begin
                    n_state = ST_IDLE;
                end else begin
                    if ($signed(blit_col_inc) >= r_blit_w) begin
                        n_blit_col = '0;
                        n_blit_row = r_blit_row + 16'd1;
                    end else begin
                        n_blit_col = blit_col_inc;
                    end
                    n_tx = bx[XW-1:0];
                    n_ty = by[YW-1:0];
                    if (bx >= 18'sd0 && bx < FW_S && by >= 18'sd0 && by < FH_S) begin
                        n_state = ST_ADDR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_READ_CHK: begin
                n_tx  = sx[XW-1:0];
                n_ty  = sy[YW-1:0];
                n_hit = (sx >= 18'sd0 && sx < FW_S && sy >= 18'sd0 && sy < FH_S);
                n_state = n_hit ? ST_ADDR : ST_RESULT;
            end
            ST_ADDR: begin
                // Shared row multiplier: linear address of (r_tx, r_ty).
                n_addr = AW'(r_ty * FRAME_WIDTH) + AW'(r_tx);
                case (r_op)
                    CMD_FILL:       n_state = ST_FILL;
                    CMD_BLIT_PIXEL: n_state = ST_WRITE;
                    default:        n_state = ST_READ;
                endcase
            end
            ST_FILL: begin
                w_we = 1'b1;
                if (fill_row_end && r_ty == r_yl) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + addr_inc;
                    if (fill_row_end) begin
                        n_tx = r_x0;
                        n_ty = r_ty + YW'(1);
                    end else begin
                        n_tx = r_tx + XW'(1);
                    end
                end
            end
            ST_WRITE: begin
                w_we    = 1'b1;
                n_state = ST_IDLE;
            end
            ST_READ: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_hit ? r_rd_data : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The store is written only by the zeroing sweep, the fill walk or a blit pixel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_CLEAR || r_state == ST_FILL || r_state == ST_WRITE))
        else $error("frame store written outside a write state");

    // Every write lands inside the frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_addr <= LAST_ADDR))
        else $error("frame store write beyond the last pixel");

    // A result appears only after the read sequence reaches its final step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_RESULT)
        else $error("result register loaded outside the read sequence");

    // The bitmap column stays inside the recorded width.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blit_w > 16'sd0) |-> ($signed(r_blit_col) < r_blit_w))
        else $error("bitmap column ran past the bitmap width");

endmodule

>>> dv/tb_clipped_rect_fill_blit_framebuffer_top.sv
// Self-checking testbench for the clipped rectangle fill and bitmap blit framebuffer.
module tb_clipped_rect_fill_blit_framebuffer_top;
    import crfb_pkg::*;

    localparam int FW = 320;
    localparam int FH = 240;
    localparam int FRAME_PIXELS = FW * FH;
    // Fills covering more than this many pixels are rationed by queue_fill.
    localparam int BIG_AREA = 4096;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 32;
    localparam logic [2:0] RESERVED_CMDS [3] = '{3'd5, 3'd6, 3'd7};

    typedef struct {
        logic [2:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] span_w;
        logic signed [15:0] span_h;
        logic [15:0]        color;
    } t_fb_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // Fields from bit 0 up: pos_x, pos_y, span_w, span_h, color.
    logic [79:0] i_s_axis_tdata = '0;
    // Fields from bit 0 up: cmd.
    logic [2:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // Fields from bit 0 up: pixel_value.
    logic [15:0] o_m_axis_tdata;

    // Shadow copy of the frame and of the bitmap progress.
    logic [15:0] shadow_pixels [FRAME_PIXELS];
    int bmp_org_x, bmp_org_y, bmp_w, bmp_h, bmp_row, bmp_col;

    t_fb_cmd     pending_cmds [$];
    t_fb_cmd     in_flight;
    logic [15:0] expected_pixels [$];

    int queued_count = 0;
    int accepted_count = 0;
    int fail_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int big_fills_left = 6;
    int clears_left = 2;

    clipped_rect_fill_blit_framebuffer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void wipe_frame();
        foreach (shadow_pixels[i]) shadow_pixels[i] = '0;
    endfunction

    function automatic bit on_frame(int x, int y);
        return x >= 0 && x < FW && y >= 0 && y < FH;
    endfunction

    // Mirrors a negative span onto the other side of pos and clips it to [0, limit).
    // An empty result comes back as hi <= lo.
    function automatic void clip_span(input int pos, input int span, input int limit,
                                      output int lo, output int hi);
        int p, s;
        p = pos;
        s = span;
        if (s < 0) begin
            p = p + s + 1;
            s = -s;
        end
        lo = (p < 0) ? 0 : p;
        hi = (p + s > limit) ? limit : p + s;
    endfunction

    function automatic void apply_command(t_fb_cmd it);
        int x, y, x0, x1, y0, y1, tx, ty;
        x = it.pos_x;
        y = it.pos_y;
        case (it.cmd)
            CMD_FILL: begin
                clip_span(x, it.span_w, FW, x0, x1);
                clip_span(y, it.span_h, FH, y0, y1);
                for (int r = y0; r < y1; r++)
                    for (int k = x0; k < x1; k++)
                        shadow_pixels[r * FW + k] = it.color;
            end
            CMD_BLIT_START: begin
                bmp_org_x = x;
                bmp_org_y = y;
                bmp_w = it.span_w;
                bmp_h = it.span_h;
                bmp_row = 0;
                bmp_col = 0;
            end
            CMD_BLIT_PIXEL: begin
                // An empty or finished bitmap swallows the pixel without a trace.
                if (bmp_w > 0 && bmp_h > 0 && bmp_row < bmp_h) begin
                    tx = bmp_org_x + bmp_col;
                    ty = bmp_org_y + bmp_row;
                    if (on_frame(tx, ty)) shadow_pixels[ty * FW + tx] = it.color;
                    bmp_col++;
                    if (bmp_col >= bmp_w) begin
                        bmp_col = 0;
                        bmp_row++;
                    end
                end
            end
            CMD_READ: begin
                expected_pixels.push_back(on_frame(x, y) ? shadow_pixels[y * FW + x] : 16'h0);
            end
            CMD_CLEAR: wipe_frame();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic int srand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic push_cmd(logic [2:0] cmd, int x, int y, int w, int h, logic [15:0] c);
        t_fb_cmd it;
        it.cmd = cmd;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.span_w = 16'(w);
        it.span_h = 16'(h);
        it.color = c;
        pending_cmds.push_back(it);
        queued_count++;
    endtask

    // Large fills are rationed; once the allowance is spent they shrink to 3x3.
    task automatic queue_fill(int x, int y, int w, int h, logic [15:0] c);
        int x0, x1, y0, y1;
        clip_span(x, w, FW, x0, x1);
        clip_span(y, h, FH, y0, y1);
        if (x1 > x0 && y1 > y0 && (x1 - x0) * (y1 - y0) > BIG_AREA) begin
            if (big_fills_left > 0) begin
                big_fills_left--;
            end else begin
                w = (w < 0) ? -3 : 3;
                h = (h < 0) ? -3 : 3;
            end
        end
        push_cmd(CMD_FILL, x, y, w, h, c);
    endtask

    // A blit start followed by its pixels, mostly well formed, then a read or two
    // near the bitmap origin.
    task automatic queue_bitmap();
        int ox, oy, bw, bh, npix;
        ox = int'($urandom_range(0, FW + 23)) - 12;
        oy = int'($urandom_range(0, FH + 23)) - 12;
        bw = $urandom_range(1, 6);
        bh = $urandom_range(1, 6);
        npix = bw * bh;
        case ($urandom_range(0, 11))
            0: begin
                bw = -int'($urandom_range(0, 4));
                npix = 2;
            end
            1: begin
                bh = -int'($urandom_range(0, 4));
                npix = 2;
            end
            2: npix = $urandom_range(0, npix - 1);
            3: npix = npix + $urandom_range(1, 3);
            4: begin
                ox = srand16();
                oy = srand16();
            end
            5: begin
                bw = srand16();
                bh = srand16();
                npix = 4;
            end
            6: ox = 32767 - int'($urandom_range(0, 3));
            default: ;
        endcase
        push_cmd(CMD_BLIT_START, ox, oy, bw, bh, rand16());
        repeat (npix)
            push_cmd(CMD_BLIT_PIXEL, srand16(), srand16(), srand16(), srand16(), rand16());
        repeat ($urandom_range(1, 2))
            push_cmd(CMD_READ, ox + int'($urandom_range(0, 5)), oy + int'($urandom_range(0, 5)),
                     srand16(), srand16(), rand16());
    endtask

    task automatic queue_random_mix(int count);
        int goal, pick, x, y, w, h;
        goal = queued_count + count;
        while (queued_count < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 32) begin
                queue_bitmap();
            end else if (pick < 56) begin
                x = int'($urandom_range(0, FW + 39)) - 20;
                y = int'($urandom_range(0, FH + 39)) - 20;
                w = int'($urandom_range(0, 32)) - 16;
                h = int'($urandom_range(0, 32)) - 16;
                queue_fill(x, y, w, h, rand16());
                push_cmd(CMD_READ, x + int'($urandom_range(0, 4)) - 2,
                         y + int'($urandom_range(0, 4)) - 2, srand16(), srand16(), rand16());
            end else if (pick < 78) begin
                if ($urandom_range(0, 4) == 0) begin
                    x = srand16();
                    y = srand16();
                end else begin
                    x = int'($urandom_range(0, FW + 3)) - 2;
                    y = int'($urandom_range(0, FH + 3)) - 2;
                end
                push_cmd(CMD_READ, x, y, srand16(), srand16(), rand16());
            end else if (pick < 86) begin
                queue_fill(srand16(), srand16(), srand16(), srand16(), rand16());
            end else if (pick < 90) begin
                push_cmd(RESERVED_CMDS[$urandom_range(0, 2)], srand16(), srand16(),
                         srand16(), srand16(), rand16());
            end else if (pick < 92 && clears_left > 0) begin
                clears_left--;
                push_cmd(CMD_CLEAR, srand16(), srand16(), srand16(), srand16(), rand16());
            end else if (pick < 95) begin
                w = $urandom_range(100, 400);
                h = $urandom_range(80, 300);
                if ($urandom_range(0, 1) != 0) w = -w;
                if ($urandom_range(0, 1) != 0) h = -h;
                queue_fill(int'($urandom_range(0, 140)) - 40, int'($urandom_range(0, 120)) - 40,
                           w, h, rand16());
            end else begin
                // A stray pixel outside any planned bitmap.
                push_cmd(CMD_BLIT_PIXEL, srand16(), srand16(), srand16(), srand16(), rand16());
            end
        end
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count) @(posedge i_clk);
        for (int n = 0; n < DRAIN_LIMIT && expected_pixels.size() != 0; n++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Command driver: each accepted transfer goes through the predictor.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            wipe_frame();
            bmp_org_x = 0;
            bmp_org_y = 0;
            bmp_w = 0;
            bmp_h = 0;
            bmp_row = 0;
            bmp_col = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_command(in_flight);
                accepted_count++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    in_flight = pending_cmds.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= in_flight.cmd;
                    i_s_axis_tdata <= {in_flight.color, in_flight.span_h, in_flight.span_w,
                                       in_flight.pos_y, in_flight.pos_x};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random back-pressure.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_check
        logic [15:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel_value: unexpected transfer, got %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (o_m_axis_tdata !== want) begin
                    $error("pixel_value: expected %h, got %h", want, o_m_axis_tdata);
                    fail_count++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        #12000000;
        $display("clipped_rect_fill_blit_framebuffer_top verification failed");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The store reads back zero after the reset pass.
        push_cmd(CMD_READ, 0, 0, 0, 0, 16'h0);
        // Mirrored extremes: left edge lands exactly on column 0, covering the frame.
        queue_fill(32767, 32767, -32768, -32768, 16'h5A5A);
        // Zero width, then zero height: nothing changes.
        queue_fill(10, 10, 0, 5, 16'h1234);
        queue_fill(10, 10, 5, 0, 16'h1234);
        // Negative size spans columns 16..20 and rows 28..30.
        queue_fill(20, 30, -5, -3, 16'h00FF);
        push_cmd(CMD_READ, 16, 28, -1, -1, 16'hFFFF);
        // Clipped at the bottom right corner.
        queue_fill(FW - 5, FH - 5, 32767, 32767, 16'h07E0);
        push_cmd(CMD_READ, FW - 1, FH - 1, 0, 0, 16'h0);
        push_cmd(CMD_READ, 32767, -32768, 32767, -32768, 16'hFFFF);
        push_cmd(CMD_READ, -1, 0, 0, 0, 16'h0);
        // Bitmap straddling the right and top edges, with one pixel too many.
        push_cmd(CMD_BLIT_START, FW - 1, -1, 2, 2, 16'h0);
        for (int k = 0; k < 5; k++)
            push_cmd(CMD_BLIT_PIXEL, 0, 0, 0, 0, 16'hA000 + 16'(k));
        push_cmd(CMD_READ, FW - 1, 0, 0, 0, 16'h0);
        // Empty bitmap: its pixel is ignored.
        push_cmd(CMD_BLIT_START, 5, 5, -2, 0, 16'h0);
        push_cmd(CMD_BLIT_PIXEL, 0, 0, 0, 0, 16'hBEEF);
        // A restart drops the first bitmap; a clear keeps the bitmap position.
        push_cmd(CMD_BLIT_START, 50, 50, 2, 2, 16'h0);
        push_cmd(CMD_BLIT_PIXEL, 0, 0, 0, 0, 16'h1111);
        push_cmd(CMD_BLIT_START, 60, 60, 2, 2, 16'h0);
        push_cmd(CMD_BLIT_PIXEL, 0, 0, 0, 0, 16'h2222);
        push_cmd(CMD_CLEAR, 0, 0, 0, 0, 16'h0);
        push_cmd(CMD_BLIT_PIXEL, 0, 0, 0, 0, 16'h3333);
        push_cmd(CMD_READ, 61, 60, 0, 0, 16'h0);
        push_cmd(CMD_READ, 60, 60, 0, 0, 16'h0);
        foreach (RESERVED_CMDS[i])
            push_cmd(RESERVED_CMDS[i], 7, 7, 7, 7, 16'hFFFF);

        // Random part in four pressure phases.
        idle_pct = 0;
        stall_pct = 0;
        queue_random_mix(ITEMS_PER_PHASE);
        wait_drained();

        idle_pct = 61;
        stall_pct = 0;
        queue_random_mix(ITEMS_PER_PHASE);
        wait_drained();

        idle_pct = 0;
        stall_pct = 61;
        queue_random_mix(ITEMS_PER_PHASE);
        wait_drained();

        idle_pct = 29;
        stall_pct = 29;
        queue_random_mix(ITEMS_PER_PHASE);
        wait_drained();

        if (expected_pixels.size() != 0) begin
            $error("pixel_value: %0d read results never arrived", expected_pixels.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("clipped_rect_fill_blit_framebuffer_top verification clean");
        end else begin
            $display("clipped_rect_fill_blit_framebuffer_top verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/crfb_pkg.sv
src/clipped_rect_fill_blit_framebuffer_top.sv
dv/tb_clipped_rect_fill_blit_framebuffer_top.sv
